// File: design/psieve_pkg.sv
// Package for the prime sieve engine: sizes, state encoding and residue helpers.
// No dependencies; prime_sieve_engine_top imports it.
package psieve_pkg;

  localparam int MAX_LIMIT = 65535;
  localparam int FLAG_DEPTH = MAX_LIMIT + 1;
  localparam int FLAG_AW = $clog2(FLAG_DEPTH);

  localparam logic OP_START = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic KIND_ERAT = 1'b0;
  localparam logic KIND_ATKIN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_TRD,
    ST_TWR,
    ST_SEED2,
    ST_SEED3,
    ST_PRD,
    ST_PCHK,
    ST_CROSS,
    ST_FRD,
    ST_FCHK,
    ST_RESP
  } psieve_state_t;

  // x*x mod 12 from x mod 6
  function automatic logic [3:0] sq_mod12(input logic [2:0] r6);
    logic [3:0] v;
    unique case (r6)
      3'd0: v = 4'd0;
      3'd1: v = 4'd1;
      3'd2: v = 4'd4;
      3'd3: v = 4'd9;
      3'd4: v = 4'd4;
      3'd5: v = 4'd1;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  // reduce a small value (below 60) modulo 12
  function automatic logic [3:0] mod12_small(input logic [5:0] v);
    logic [5:0] t;
    t = v;
    for (int i = 0; i < 4; i++) begin
      if (t >= 6'd12) t = t - 6'd12;
    end
    return t[3:0];
  endfunction

endpackage

// File: design/psieve_in_if.sv
// Request channel interface: valid/ready plus operation and limit.
// Depends on nothing.
interface psieve_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] limit;
  modport source (output valid, output operation, output limit, input ready);
  modport sink (input valid, input operation, input limit, output ready);
endinterface

// File: design/psieve_out_if.sv
// Result channel interface: valid/ready plus prime, found and sieve_done.
// Depends on nothing.
interface psieve_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] prime;
  logic        found;
  logic        sieve_done;
  modport source (output valid, output prime, output found, output sieve_done, input ready);
  modport sink (input valid, input prime, input found, input sieve_done, output ready);
endinterface

// File: design/prime_sieve_engine_top.sv
// Prime sieve engine top level: sequencer around one flag memory.
// Depends on psieve_pkg, psieve_in_if, psieve_out_if and psieve_ram.
//
// Usage:
//   in_req carries requests. operation START rebuilds the primality store for
//   0..limit with the sieve picked by cfg_data (0 Eratosthenes, 1 Atkin),
//   written while cfg_we is high. operation FETCH returns the next prime in
//   ascending order, or found 0 once the list is exhausted.
//   out_rsp carries one result per request; a start answers sieve_done 1.
// Operation:
//   Start runs a clear pass over 0..limit, then the sieve. Eratosthenes
//   reads each candidate p up to sqrt(limit) and crosses each multiple of a
//   prime; Atkin reads the flag of each quadratic form for every (x,y) pair
//   and toggles it on a hit (one read-modify-write through the flag memory
//   port), followed by the square-crossing pass. A fetch scans the flags in
//   ascending order until it finds a prime or passes the limit, and the next
//   request is taken once the sequencer is back in IDLE; the scan is set by
//   the single read port of the flag memory. Every result leaves through the
//   output register, loaded as the sequencer leaves RESP.
// Reset: synchronous, active-low rst_n; the sieve kind returns to Atkin, the
//   list is empty and the store is undefined until the first start.
// Stall: a finished result waits in the output register; the next request is
//   taken meanwhile but its result holds until the register frees.
module prime_sieve_engine_top
  import psieve_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  psieve_in_if.sink       in_req,
  psieve_out_if.source    out_rsp,
  input  logic            cfg_we,
  input  logic            cfg_data
);

  psieve_state_t state_r, state_nxt;

  logic        sk_r;
  logic [15:0] n_r;
  logic [15:0] lim_r;
  logic [16:0] scan_r, scan_nxt;
  logic [17:0] m_r, m_nxt;
  logic [8:0]  p_r, p_nxt;
  logic [17:0] pp_r, pp_nxt;
  logic [8:0]  x_r, x_nxt, y_r, y_nxt;
  logic [16:0] xx_r, xx_nxt, yy_r, yy_nxt;
  logic [2:0]  xm_r, xm_nxt, ym_r, ym_nxt;
  logic [1:0]  f_r, f_nxt;
  logic [15:0] k_r, k_nxt;

  logic [15:0] res_prime_r, res_prime_nxt;
  logic        res_found_r, res_found_nxt;
  logic        res_done_r, res_done_nxt;
  logic        out_valid_r;
  logic [15:0] out_prime_r;
  logic        out_found_r, out_done_r;

  logic               we;
  logic [FLAG_AW-1:0] waddr, raddr;
  logic               wdata, rdata;

  psieve_ram #(.WIDTH(1), .DEPTH(FLAG_DEPTH)) u_flags (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared conditions
  logic in_fire, out_free;
  logic clr_end, p_end, cross_end, x_end, y_end, f_last;
  logic scan_over, nxt_over;
  logic [16:0] scan_inc;
  logic [17:0] step;
  logic [3:0] sx, sy, r0, r1, r2;
  logic [19:0] k0, k1, k2, ksel;
  logic c0, c1, c2, hit;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire  = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_rsp.ready;

  assign clr_end   = m_r > {2'b0, n_r};
  assign p_end     = pp_r > {2'b0, n_r};
  assign cross_end = m_r > {2'b0, n_r};
  assign x_end     = xx_r > {1'b0, n_r};
  assign y_end     = yy_r > {1'b0, n_r};
  assign f_last    = (f_r == 2'd2);
  assign scan_inc  = scan_r + 17'd1;
  assign scan_over = scan_r > {1'b0, lim_r};
  assign nxt_over  = scan_inc > {1'b0, lim_r};
  assign step      = (sk_r == KIND_ATKIN) ? pp_r : {9'b0, p_r};

  // quadratic forms and their residues
  assign sx = sq_mod12(xm_r);
  assign sy = sq_mod12(ym_r);
  assign k0 = {1'b0, xx_r, 2'b0} + {3'b0, yy_r};
  assign k1 = {1'b0, xx_r, 2'b0} - {3'b0, xx_r} + {3'b0, yy_r};
  assign k2 = {1'b0, xx_r, 2'b0} - {3'b0, xx_r} - {3'b0, yy_r};
  assign r0 = mod12_small({sx, 2'b0} + {2'b0, sy});
  assign r1 = mod12_small({1'b0, sx, 1'b0} + {2'b0, sx} + {2'b0, sy});
  assign r2 = mod12_small({1'b0, sx, 1'b0} + {2'b0, sx} + 6'd12 - {2'b0, sy});
  assign c0 = (k0 <= {4'b0, n_r}) && (r0 == 4'd1 || r0 == 4'd5);
  assign c1 = (k1 <= {4'b0, n_r}) && (r1 == 4'd7);
  assign c2 = (x_r > y_r) && (k2 <= {4'b0, n_r}) && (r2 == 4'd11);

  always_comb begin
    unique case (f_r)
      2'd0:    begin ksel = k0; hit = c0; end
      2'd1:    begin ksel = k1; hit = c1; end
      default: begin ksel = k2; hit = c2; end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = (in_req.operation == OP_START) ? ST_CLR : ST_FRD;
      ST_CLR:   if (clr_end) state_nxt = (sk_r == KIND_ATKIN) ? ST_TRD : ST_PRD;
      ST_TRD: begin
        if (x_end) state_nxt = ST_SEED2;
        else if (!y_end && hit) state_nxt = ST_TWR;
      end
      ST_TWR:   state_nxt = ST_TRD;
      ST_SEED2: state_nxt = ST_SEED3;
      ST_SEED3: state_nxt = ST_PRD;
      ST_PRD:   state_nxt = p_end ? ST_RESP : ST_PCHK;
      ST_PCHK:  state_nxt = rdata ? ST_CROSS : ST_PRD;
      ST_CROSS: if (cross_end) state_nxt = ST_PRD;
      ST_FRD:   state_nxt = scan_over ? ST_RESP : ST_FCHK;
      ST_FCHK:  if (rdata || nxt_over) state_nxt = ST_RESP;
      ST_RESP:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    scan_nxt = scan_r;
    m_nxt = m_r;
    p_nxt = p_r;
    pp_nxt = pp_r;
    x_nxt = x_r;
    y_nxt = y_r;
    xx_nxt = xx_r;
    yy_nxt = yy_r;
    xm_nxt = xm_r;
    ym_nxt = ym_r;
    f_nxt = f_r;
    k_nxt = k_r;
    res_prime_nxt = res_prime_r;
    res_found_nxt = res_found_r;
    res_done_nxt = res_done_r;
    we = 1'b0;
    waddr = m_r[FLAG_AW-1:0];
    wdata = 1'b0;
    raddr = scan_r[FLAG_AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        res_prime_nxt = '0;
        res_found_nxt = 1'b0;
        res_done_nxt = (in_req.operation == OP_START);
        if (in_fire && in_req.operation == OP_START) begin
          m_nxt = '0;
          scan_nxt = 17'd2;
        end
      end
      ST_CLR: begin
        if (clr_end) begin
          p_nxt = 9'd2;
          pp_nxt = 18'd4;
          x_nxt = 9'd1;
          xx_nxt = 17'd1;
          xm_nxt = 3'd1;
          y_nxt = 9'd1;
          yy_nxt = 17'd1;
          ym_nxt = 3'd1;
          f_nxt = 2'd0;
        end else begin
          we = 1'b1;
          wdata = (sk_r == KIND_ERAT) && (m_r >= 18'd2);
          m_nxt = m_r + 18'd1;
        end
      end
      ST_TRD: begin
        raddr = ksel[FLAG_AW-1:0];
        k_nxt = ksel[15:0];
        if (!x_end) begin
          if (y_end) begin
            // next row: x advances, y restarts at 1
            xx_nxt = xx_r + {7'b0, x_r, 1'b1};
            x_nxt = x_r + 9'd1;
            xm_nxt = (xm_r == 3'd5) ? 3'd0 : xm_r + 3'd1;
            y_nxt = 9'd1;
            yy_nxt = 17'd1;
            ym_nxt = 3'd1;
            f_nxt = 2'd0;
          end else if (!hit) begin
            if (f_last) begin
              f_nxt = 2'd0;
              yy_nxt = yy_r + {7'b0, y_r, 1'b1};
              y_nxt = y_r + 9'd1;
              ym_nxt = (ym_r == 3'd5) ? 3'd0 : ym_r + 3'd1;
            end else begin
              f_nxt = f_r + 2'd1;
            end
          end
        end
      end
      ST_TWR: begin
        // toggle the entry read last cycle
        we = 1'b1;
        waddr = k_r;
        wdata = ~rdata;
        if (f_last) begin
          f_nxt = 2'd0;
          yy_nxt = yy_r + {7'b0, y_r, 1'b1};
          y_nxt = y_r + 9'd1;
          ym_nxt = (ym_r == 3'd5) ? 3'd0 : ym_r + 3'd1;
        end else begin
          f_nxt = f_r + 2'd1;
        end
      end
      ST_SEED2: begin
        we = (n_r >= 16'd2);
        waddr = FLAG_AW'(2);
        wdata = 1'b1;
      end
      ST_SEED3: begin
        we = (n_r >= 16'd3);
        waddr = FLAG_AW'(3);
        wdata = 1'b1;
        p_nxt = 9'd5;
        pp_nxt = 18'd25;
      end
      ST_PRD: begin
        raddr = {{(FLAG_AW-9){1'b0}}, p_r};
      end
      ST_PCHK: begin
        if (rdata) begin
          m_nxt = pp_r;
        end else begin
          pp_nxt = pp_r + {8'b0, p_r, 1'b1};
          p_nxt = p_r + 9'd1;
        end
      end
      ST_CROSS: begin
        if (cross_end) begin
          pp_nxt = pp_r + {8'b0, p_r, 1'b1};
          p_nxt = p_r + 9'd1;
        end else begin
          we = 1'b1;
          wdata = 1'b0;
          m_nxt = m_r + step;
        end
      end
      ST_FRD: begin
        raddr = scan_r[FLAG_AW-1:0];
      end
      ST_FCHK: begin
        raddr = scan_inc[FLAG_AW-1:0];
        if (rdata) begin
          res_prime_nxt = scan_r[15:0];
          res_found_nxt = 1'b1;
          scan_nxt = scan_inc;
        end else if (nxt_over) begin
          scan_nxt = {1'b0, lim_r} + 17'd1;
        end else begin
          scan_nxt = scan_inc;
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sk_r <= KIND_ATKIN;
      lim_r <= '0;
      scan_r <= 17'd2;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      scan_r <= scan_nxt;
      if (cfg_we) sk_r <= cfg_data;
      if (in_fire && in_req.operation == OP_START) lim_r <= in_req.limit;
      if (state_r == ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire && in_req.operation == OP_START) n_r <= in_req.limit;
    m_r <= m_nxt;
    p_r <= p_nxt;
    pp_r <= pp_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    xx_r <= xx_nxt;
    yy_r <= yy_nxt;
    xm_r <= xm_nxt;
    ym_r <= ym_nxt;
    f_r <= f_nxt;
    k_r <= k_nxt;
    res_prime_r <= res_prime_nxt;
    res_found_r <= res_found_nxt;
    res_done_r <= res_done_nxt;
    if (state_r == ST_RESP && out_free) begin
      out_prime_r <= res_prime_r;
      out_found_r <= res_found_r;
      out_done_r <= res_done_r;
    end
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.prime = out_prime_r;
  assign out_rsp.found = out_found_r;
  assign out_rsp.sieve_done = out_done_r;

endmodule

// File: design/psieve_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module psieve_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
